>>> rtl/core/jptc_pkg.sv
// Shared constants for the joystick pan/tilt trigger controller.
`timescale 1ns / 1ps

package jptc_pkg;

  // Default structural parameters
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int TIME_BITS_DEF   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register widths
  localparam int SMP_REG_W  = 10;  // center, dead zone, divisor
  localparam int MS_REG_W   = 16;  // settle and burst times
  localparam int ANGLE_W    = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TIME    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX     = 3'd7;

  // Register reset values
  localparam logic [SMP_REG_W-1:0] CENTER_RST    = 10'd512;
  localparam logic [SMP_REG_W-1:0] DEAD_ZONE_RST = 10'd20;
  localparam logic [SMP_REG_W-1:0] DIVISOR_RST   = 10'd100;
  localparam logic [MS_REG_W-1:0]  SETTLE_RST    = 16'd400;
  localparam logic [MS_REG_W-1:0]  BURST_RST     = 16'd2000;
  localparam logic [ANGLE_W-1:0]   ANGLE_MIN_RST = 8'd0;
  localparam logic [ANGLE_W-1:0]   ANGLE_MAX_RST = 8'd180;
  localparam logic [ANGLE_W-1:0]   ANGLE_HOME    = 8'd90;

  // Result packing: pan, tilt, pump, drive, padded to whole bytes
  localparam int OUT_FIELDS_W = 2 * ANGLE_W + 2;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD      = OUT_W - OUT_FIELDS_W;

endpackage

>>> rtl/core/joystick_pan_tilt_trigger_controller.sv
// Joystick pan/tilt aiming with a timed pump burst, bit-serial divider.
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload (lowest bit up)
// s_axis    in   s_tvalid / s_tready    joy_x, joy_y, button_down, now_ms
// m_axis    out  m_tvalid / m_tready    pan_angle, tilt_angle, pump_on, servo_drive_on
// cfg       in   cfg_we                 cfg_index selects register, cfg_wdata value
//
// A transaction is accepted in idle, then passes through the prep, divide, angle and
// update states; the restoring divider retires one quotient bit per cycle for both
// axes side by side. A new input is taken once the state machine is back in idle,
// even while the previous result still waits in the output register. A stalled
// output holds the block in its final step. Reset (rst, synchronous) restores the
// configuration registers, controller state, sequencer state and m_tvalid to defaults.

module joystick_pan_tilt_trigger_controller #(
  parameter int SAMPLE_BITS = jptc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = jptc_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // joy_x, joy_y, button_down, now_ms, zero pad
  input  logic [((2*SAMPLE_BITS+TIME_BITS+8)/8)*8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pan_angle, tilt_angle, pump_on, servo_drive_on, zero pad
  output logic [jptc_pkg::OUT_W-1:0]           m_tdata,
  input  logic                                 cfg_we,
  input  logic [jptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jptc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int TB    = TIME_BITS;
  localparam int RW    = jptc_pkg::SMP_REG_W;
  localparam int AW_   = jptc_pkg::ANGLE_W;
  localparam int CMPW  = (SB > RW) ? SB : RW;   // dead zone compare width
  localparam int VW    = SB + RW;               // signed angle arithmetic width
  localparam int CNTW  = $clog2(SB);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ANGLE  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  // Configuration registers
  logic [RW-1:0]                   center_x, center_y, dead_zone, divisor;
  logic [jptc_pkg::MS_REG_W-1:0]   settle_time_ms, burst_time_ms;
  logic [AW_-1:0]                  angle_min, angle_max;

  // Controller state
  logic [AW_-1:0] pan_now, tilt_now;
  logic           trigger_armed, burst_active, drive_enabled;
  logic [TB-1:0]  burst_start, last_activity;

  // Per-transaction working registers
  logic [2:0]      state;
  logic [SB-1:0]   joy_x, joy_y;
  logic            btn;
  logic [TB-1:0]   now_ms;
  logic [SB-1:0]   dq_x, dq_y;     // dividend shifts out, quotient shifts in
  logic [RW-1:0]   rem_x, rem_y;
  logic            neg_x, neg_y;
  logic [CNTW-1:0] bit_cnt;
  logic [AW_-1:0]  new_pan, new_tilt;
  logic            burst_elapsed, idle_exceeded;

  // Field unpacking
  logic [SB-1:0] in_x, in_y;
  logic          in_btn;
  logic [TB-1:0] in_now;
  assign in_x   = s_tdata[SB-1:0];
  assign in_y   = s_tdata[2*SB-1:SB];
  assign in_btn = s_tdata[2*SB];
  assign in_now = s_tdata[2*SB+TB:2*SB+1];

  assign s_tready = (state == ST_IDLE);

  // Offset, magnitude and dead zone for both axes
  logic [SB-1:0]   cx_eff, cy_eff;
  logic [SB:0]     off_x, off_y;
  logic [SB-1:0]   mag_x, mag_y;
  logic            dz_x, dz_y;
  assign cx_eff = SB'(center_x);
  assign cy_eff = SB'(center_y);
  assign off_x  = {1'b0, joy_x} - {1'b0, cx_eff};
  assign off_y  = {1'b0, joy_y} - {1'b0, cy_eff};
  assign mag_x  = off_x[SB] ? SB'(-off_x) : off_x[SB-1:0];
  assign mag_y  = off_y[SB] ? SB'(-off_y) : off_y[SB-1:0];
  assign dz_x   = CMPW'(mag_x) < CMPW'(dead_zone);
  assign dz_y   = CMPW'(mag_y) < CMPW'(dead_zone);

  // One restoring division step per lane
  logic [RW-1:0] div_eff;
  logic [RW:0]   trial_x, trial_y;
  logic          ge_x, ge_y;
  logic [RW:0]   diff_x, diff_y;
  logic [RW-1:0] rem_x_next, rem_y_next;
  assign div_eff    = (divisor == '0) ? RW'(1) : divisor;
  assign trial_x    = {rem_x, dq_x[SB-1]};
  assign trial_y    = {rem_y, dq_y[SB-1]};
  assign ge_x       = trial_x >= {1'b0, div_eff};
  assign ge_y       = trial_y >= {1'b0, div_eff};
  assign diff_x     = trial_x - {1'b0, div_eff};
  assign diff_y     = trial_y - {1'b0, div_eff};
  assign rem_x_next = ge_x ? diff_x[RW-1:0] : trial_x[RW-1:0];
  assign rem_y_next = ge_y ? diff_y[RW-1:0] : trial_y[RW-1:0];

  // Angle step and clamp
  logic signed [VW-1:0] q_x, q_y, v_pan, v_tilt, lim_lo, lim_hi;
  logic [AW_-1:0]       pan_clamped, tilt_clamped;
  assign q_x    = neg_x ? -VW'(dq_x) : VW'(dq_x);
  assign q_y    = neg_y ? -VW'(dq_y) : VW'(dq_y);
  assign v_pan  = VW'(pan_now) - q_x;
  assign v_tilt = VW'(tilt_now) - q_y;
  assign lim_lo = VW'(angle_min);
  assign lim_hi = VW'(angle_max);

  always_comb begin
    if (v_pan < lim_lo) begin
      pan_clamped = angle_min;
    end else if (v_pan > lim_hi) begin
      pan_clamped = angle_max;
    end else begin
      pan_clamped = v_pan[AW_-1:0];
    end
    if (v_tilt < lim_lo) begin
      tilt_clamped = angle_min;
    end else if (v_tilt > lim_hi) begin
      tilt_clamped = angle_max;
    end else begin
      tilt_clamped = v_tilt[AW_-1:0];
    end
  end

  // Trigger and drive decisions for the final step
  logic armed_now, fire, burst_next, moved, out_free;
  assign armed_now  = trigger_armed | ~btn;
  assign fire       = btn & armed_now & ~burst_active;
  assign burst_next = fire | (burst_active & ~burst_elapsed);
  assign moved      = ~burst_next & ((new_pan != pan_now) | (new_tilt != tilt_now));
  assign out_free   = ~m_tvalid | m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= jptc_pkg::CENTER_RST;
      center_y       <= jptc_pkg::CENTER_RST;
      dead_zone      <= jptc_pkg::DEAD_ZONE_RST;
      divisor        <= jptc_pkg::DIVISOR_RST;
      settle_time_ms <= jptc_pkg::SETTLE_RST;
      burst_time_ms  <= jptc_pkg::BURST_RST;
      angle_min      <= jptc_pkg::ANGLE_MIN_RST;
      angle_max      <= jptc_pkg::ANGLE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jptc_pkg::REG_CENTER_X:      center_x       <= cfg_wdata[RW-1:0];
        jptc_pkg::REG_CENTER_Y:      center_y       <= cfg_wdata[RW-1:0];
        jptc_pkg::REG_DEAD_ZONE:     dead_zone      <= cfg_wdata[RW-1:0];
        jptc_pkg::REG_DIVISOR:       divisor        <= cfg_wdata[RW-1:0];
        jptc_pkg::REG_SETTLE_TIME:   settle_time_ms <= cfg_wdata;
        jptc_pkg::REG_BURST_TIME:    burst_time_ms  <= cfg_wdata;
        jptc_pkg::REG_ANGLE_MIN:     angle_min      <= cfg_wdata[AW_-1:0];
        jptc_pkg::REG_ANGLE_MAX:     angle_max      <= cfg_wdata[AW_-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pan_now       <= jptc_pkg::ANGLE_HOME;
      tilt_now      <= jptc_pkg::ANGLE_HOME;
      trigger_armed <= 1'b0;
      burst_active  <= 1'b0;
      burst_start   <= '0;
      last_activity <= '0;
      drive_enabled <= 1'b1;
      m_tvalid      <= 1'b0;
    end else begin
      // Drop valid once taken, unless the final step reloads it this cycle
      if (m_tvalid && m_tready && (state != ST_UPDATE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            joy_x  <= in_x;
            joy_y  <= in_y;
            btn    <= in_btn;
            now_ms <= in_now;
            state  <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Load magnitudes, zeroed inside the dead zone
          dq_x    <= dz_x ? '0 : mag_x;
          dq_y    <= dz_y ? '0 : mag_y;
          neg_x   <= off_x[SB];
          neg_y   <= off_y[SB];
          rem_x   <= '0;
          rem_y   <= '0;
          bit_cnt <= CNTW'(SB - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          dq_x  <= {dq_x[SB-2:0], ge_x};
          dq_y  <= {dq_y[SB-2:0], ge_y};
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          // Register clamped angles and both elapsed-time checks
          new_pan       <= pan_clamped;
          new_tilt      <= tilt_clamped;
          burst_elapsed <= (now_ms - burst_start) >= TB'(burst_time_ms);
          idle_exceeded <= (now_ms - last_activity) > TB'(settle_time_ms);
          state         <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // Hold until the output register has room
          if (out_free) begin
            trigger_armed <= armed_now & ~fire;
            burst_active  <= burst_next;
            if (fire) begin
              burst_start <= now_ms;
            end
            if (moved || burst_next) begin
              drive_enabled <= 1'b1;
              last_activity <= now_ms;
              if (moved) begin
                pan_now  <= new_pan;
                tilt_now <= new_tilt;
              end
            end else if (drive_enabled && idle_exceeded) begin
              drive_enabled <= 1'b0;
            end
            m_tvalid <= 1'b1;
            m_tdata  <= {{jptc_pkg::OUT_PAD{1'b0}},
                         (moved | burst_next) | (drive_enabled & ~idle_exceeded),
                         burst_next,
                         moved ? new_tilt : tilt_now,
                         moved ? new_pan : pan_now};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
